/* rtl/uart8_pkg.sv */
package uart8_pkg;

    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int FILL_W     = 6;
    localparam int BP_W       = 16;
    localparam int ADDR_W     = 4;

    localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [1:0] REG_INVERT     = 2'd1;
    localparam logic [1:0] REG_LISTENING  = 2'd2;

    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_READ  = 3'd1;
    localparam logic [2:0] FUNC_PEEK  = 3'd2;
    localparam logic [2:0] FUNC_FLUSH = 3'd3;
    localparam logic [2:0] FUNC_WRITE = 3'd4;

    typedef struct packed {
        logic [2:0] func;
        logic       rx_level;
        logic [7:0] tx_byte;
    } t_in_item;

    typedef struct packed {
        logic              tx_line;
        logic [7:0]        read_data;
        logic              read_valid;
        logic [FILL_W-1:0] fill_count;
        logic              overflow;
        logic              tx_busy;
        logic              write_accepted;
    } t_out_item;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       flush;
        logic       clear;
        logic [7:0] data;
    } t_ring_ctl;

    typedef struct packed {
        logic              empty;
        logic [7:0]        head_data;
        logic [FILL_W-1:0] fill_next;
        logic              ovf_next;
    } t_ring_sts;

endpackage

/* rtl/uart8_8n1_transceiver_with_rx_fifo_unit.sv */
// 8N1 UART transceiver with a receive FIFO, stepped by beats. A tick beat
// advances receiver and transmitter by one bit-time unit; read, peek, flush
// and write beats are host operations. Every beat gives one result beat, which
// passes through the input register and then the result register. A new beat can be
// taken in every cycle while the result side does not stall, since the whole update
// passes combinationally from the input register to the result register and the FIFO head
// is kept prefetched from its memory. The FIFO holds RING_DEPTH-1 bytes; configuration lies on
// an APB port at 0x0 (bit period), 0x4 (invert logic) and 0x8 (listening).
module uart_8n1_transceiver_with_rx_fifo_unit import uart8_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [1:0] {
        TX_IDLE,
        TX_START,
        TX_DATA,
        TX_STOP
    } t_tx_state;

    logic [BP_W-1:0] r_bit_period;
    logic            r_invert;
    logic            r_listening;

    logic            r_in_valid;
    t_in_item        r_in;
    logic            r_out_valid;
    t_out_item       r_out;

    t_tx_state       r_tx_state;
    logic [BP_W-1:0] r_tx_cnt;
    logic [3:0]      r_tx_idx;
    logic [7:0]      r_tx_shift;

    t_tx_state       n_tx_state;
    logic [BP_W-1:0] n_tx_cnt;
    logic [3:0]      n_tx_idx;
    logic [7:0]      n_tx_shift;
    t_out_item       n_out;

    logic            out_free;
    logic            fire;
    logic            cfg_wr;
    logic [1:0]      cfg_idx;
    logic            tick;
    logic            host_rd;
    logic            rx_push;
    logic [7:0]      rx_push_data;
    t_ring_ctl       ring_ctl;
    t_ring_sts       ring_sts;
    logic [BP_W-1:0] tx_cnt_inc;
    logic [3:0]      tx_idx_inc;
    logic            write_ok;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        unique case (cfg_idx)
            REG_BIT_PERIOD: prdata = {16'd0, r_bit_period};
            REG_INVERT:     prdata = {31'd0, r_invert};
            REG_LISTENING:  prdata = {31'd0, r_listening};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BP_W'(104);
            r_invert     <= 1'b0;
            r_listening  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BIT_PERIOD: r_bit_period <= pwdata[BP_W-1:0];
                REG_INVERT:     r_invert     <= pwdata[0];
                REG_LISTENING:  r_listening  <= pwdata[0];
                default:        ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Receiver and FIFO
    assign tick    = fire && (r_in.func == FUNC_TICK);
    assign host_rd = fire && r_listening && !ring_sts.empty
                     && ((r_in.func == FUNC_READ) || (r_in.func == FUNC_PEEK));

    uart8_rx u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick),
        .i_level      (r_in.rx_level),
        .i_listening  (r_listening),
        .i_invert     (r_invert),
        .i_bit_period (r_bit_period),
        .o_push       (rx_push),
        .o_push_data  (rx_push_data)
    );

    assign ring_ctl.push  = rx_push;
    assign ring_ctl.pop   = host_rd && (r_in.func == FUNC_READ);
    assign ring_ctl.flush = fire && r_listening && (r_in.func == FUNC_FLUSH);
    assign ring_ctl.clear = cfg_wr && (cfg_idx == REG_LISTENING) && pwdata[0]
                            && !r_listening;
    assign ring_ctl.data  = rx_push_data;

    uart8_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ring_ctl),
        .o_sts   (ring_sts)
    );

    // Transmitter
    assign tx_cnt_inc = r_tx_cnt + BP_W'(1);
    assign tx_idx_inc = r_tx_idx + 4'd1;
    assign write_ok   = fire && (r_in.func == FUNC_WRITE) && (r_tx_state == TX_IDLE);

    always_comb begin
        n_tx_state = r_tx_state;
        n_tx_cnt   = r_tx_cnt;
        n_tx_idx   = r_tx_idx;
        n_tx_shift = r_tx_shift;
        if (write_ok) begin
            n_tx_shift = r_invert ? ~r_in.tx_byte : r_in.tx_byte;
            n_tx_state = TX_START;
            n_tx_cnt   = '0;
            n_tx_idx   = '0;
        end else if (tick && (r_tx_state != TX_IDLE)) begin
            if (tx_cnt_inc < r_bit_period) begin
                n_tx_cnt = tx_cnt_inc;
            end else begin
                n_tx_cnt = '0;
                unique case (r_tx_state)
                    TX_START: begin
                        n_tx_state = TX_DATA;
                        n_tx_idx   = '0;
                    end
                    TX_DATA: begin
                        n_tx_idx = tx_idx_inc;
                        if (tx_idx_inc >= 4'd8) begin
                            n_tx_state = TX_STOP;
                        end
                    end
                    default: begin
                        n_tx_state = TX_IDLE;
                    end
                endcase
            end
        end
    end

    // Result of the beat being processed
    always_comb begin
        unique case (n_tx_state)
            TX_START: n_out.tx_line = r_invert;
            TX_DATA:  n_out.tx_line = n_tx_shift[n_tx_idx[2:0]];
            default:  n_out.tx_line = !r_invert;
        endcase
        n_out.read_data      = host_rd ? ring_sts.head_data : 8'd0;
        n_out.read_valid     = host_rd;
        n_out.fill_count     = r_listening ? ring_sts.fill_next : '0;
        n_out.overflow       = ring_sts.ovf_next;
        n_out.tx_busy        = (n_tx_state != TX_IDLE);
        n_out.write_accepted = write_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_state  <= TX_IDLE;
            r_tx_cnt    <= '0;
            r_tx_idx    <= '0;
            r_tx_shift  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_tx_state <= n_tx_state;
            r_tx_cnt   <= n_tx_cnt;
            r_tx_idx   <= n_tx_idx;
            r_tx_shift <= n_tx_shift;
            if (fire) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/uart8_rx.sv */
module uart8_rx import uart8_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tick,
    input  logic            i_level,
    input  logic            i_listening,
    input  logic            i_invert,
    input  logic [BP_W-1:0] i_bit_period,
    output logic            o_push,
    output logic [7:0]      o_push_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_DATA,
        ST_STOP
    } t_rx_state;

    t_rx_state       r_state;
    logic [BP_W-1:0] r_cnt;
    logic [3:0]      r_idx;
    logic [7:0]      r_shift;

    logic [BP_W-1:0] cnt_inc;
    logic [BP_W-1:0] half_period;
    logic [3:0]      idx_inc;

    assign cnt_inc     = r_cnt + BP_W'(1);
    assign half_period = i_bit_period >> 1;
    assign idx_inc     = r_idx + 4'd1;

    assign o_push      = i_tick && i_listening && (r_state == ST_STOP)
                         && (cnt_inc >= i_bit_period);
    assign o_push_data = i_invert ? ~r_shift : r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_shift <= '0;
        end else if (!i_listening) begin
            // A receiver that is switched off drops any frame in progress.
            r_state <= ST_IDLE;
        end else if (i_tick) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_level == i_invert) begin
                        r_state <= ST_FIRST;
                        r_cnt   <= '0;
                        r_idx   <= '0;
                        r_shift <= '0;
                    end
                end
                ST_FIRST: begin
                    if (cnt_inc >= half_period) begin
                        r_state <= ST_DATA;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= cnt_inc;
                    end
                end
                ST_DATA: begin
                    if (cnt_inc >= i_bit_period) begin
                        r_cnt <= '0;
                        r_shift[r_idx[2:0]] <= r_shift[r_idx[2:0]] | i_level;
                        r_idx <= idx_inc;
                        if (idx_inc >= 4'd8) begin
                            r_state <= ST_STOP;
                        end
                    end else begin
                        r_cnt <= cnt_inc;
                    end
                end
                ST_STOP: begin
                    if (cnt_inc >= i_bit_period) begin
                        r_cnt   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= cnt_inc;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/uart8_ring.sv */
module uart8_ring import uart8_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ring_ctl i_ctl,
    output t_ring_sts o_sts
);

    logic [7:0]         r_mem [RING_DEPTH];
    logic [7:0]         r_head_data;
    logic [RING_AW-1:0] r_head;
    logic [RING_AW-1:0] r_tail;
    logic               r_ovf;

    logic [RING_AW-1:0] n_head;
    logic [RING_AW-1:0] n_tail;
    logic               n_ovf;
    logic [RING_AW-1:0] tail_next;
    logic               full;
    logic               wr_en;
    logic [RING_AW:0]   fill_wide;

    function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] ptr);
        logic [RING_AW-1:0] res;
        if (ptr == RING_AW'(RING_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + RING_AW'(1);
        end
        return res;
    endfunction

    assign tail_next = ring_next(r_tail);
    assign full      = (tail_next == r_head);

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_ovf  = r_ovf;
        wr_en  = 1'b0;
        if (i_ctl.clear) begin
            n_head = '0;
            n_tail = '0;
            n_ovf  = 1'b0;
        end else if (i_ctl.flush) begin
            n_head = '0;
            n_tail = '0;
        end else begin
            if (i_ctl.push) begin
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    wr_en  = 1'b1;
                    n_tail = tail_next;
                end
            end
            if (i_ctl.pop) begin
                n_head = ring_next(r_head);
            end
        end
    end

    always_comb begin
        if (n_tail >= n_head) begin
            fill_wide = {1'b0, n_tail} - {1'b0, n_head};
        end else begin
            fill_wide = (RING_AW + 1)'(RING_DEPTH) + {1'b0, n_tail} - {1'b0, n_head};
        end
    end

    assign o_sts.empty     = (r_head == r_tail);
    assign o_sts.head_data = r_head_data;
    assign o_sts.fill_next = FILL_W'(fill_wide[RING_AW-1:0]);
    assign o_sts.ovf_next  = n_ovf;

    // The entry at the head is fetched ahead of time, so a read or peek
    // finds it in a register. A write to the new head address is forwarded.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= i_ctl.data;
        end
        if (wr_en && (r_tail == n_head)) begin
            r_head_data <= i_ctl.data;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_ovf  <= n_ovf;
        end
    end

endmodule

/* bench/uart8_link_checker.sv */
`timescale 1ns / 1ps

module uart8_link_checker import uart8_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_item          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_item         i_out_data,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output int                o_pending,
    output int                o_fail_count
);

    typedef enum logic [1:0] {SER_IDLE, SER_START, SER_DATA, SER_STOP} t_ser_phase;

    logic [BP_W-1:0]    bit_period;
    logic               invert_en;
    logic               listen_en;

    t_ser_phase         rx_phase;
    logic [BP_W-1:0]    rx_ticks;
    logic [3:0]         rx_bit;
    logic [7:0]         rx_byte;
    logic [7:0]         ring_mem [RING_DEPTH];
    logic [RING_AW-1:0] ring_rd;
    logic [RING_AW-1:0] ring_wr;
    logic               overflow_seen;
    t_ser_phase         tx_phase;
    logic [BP_W-1:0]    tx_ticks;
    logic [3:0]         tx_bit;
    logic [7:0]         tx_byte;

    t_out_item          predicted_results[$];

    task automatic clear_uart_state();
        bit_period    = BP_W'(104);
        invert_en     = 1'b0;
        listen_en     = 1'b0;
        rx_phase      = SER_IDLE;
        rx_ticks      = '0;
        rx_bit        = '0;
        rx_byte       = '0;
        ring_rd       = '0;
        ring_wr       = '0;
        overflow_seen = 1'b0;
        tx_phase      = SER_IDLE;
        tx_ticks      = '0;
        tx_bit        = '0;
        tx_byte       = '0;
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        case (idx)
            REG_BIT_PERIOD: bit_period = value[BP_W-1:0];
            REG_INVERT:     invert_en = value[0];
            REG_LISTENING: begin
                // Turning the receiver on starts from an empty ring.
                if (value[0] && !listen_en) begin
                    ring_rd       = '0;
                    ring_wr       = '0;
                    overflow_seen = 1'b0;
                end
                if (!value[0])
                    rx_phase = SER_IDLE;
                listen_en = value[0];
            end
            default: ;
        endcase
    endtask

    task automatic push_received(input logic [7:0] value);
        logic [RING_AW-1:0] next_wr;
        next_wr = ring_wr + 1'b1;
        if (next_wr != ring_rd) begin
            ring_mem[ring_wr] = value;
            ring_wr = next_wr;
        end else begin
            overflow_seen = 1'b1;
        end
    endtask

    task automatic advance_receiver(input logic level);
        if (!listen_en) begin
            rx_phase = SER_IDLE;
        end else begin
            case (rx_phase)
                SER_IDLE: begin
                    if (level == invert_en) begin
                        rx_phase = SER_START;
                        rx_ticks = '0;
                        rx_bit   = '0;
                        rx_byte  = '0;
                    end
                end
                SER_START: begin
                    rx_ticks = rx_ticks + 1'b1;
                    if (rx_ticks >= (bit_period >> 1)) begin
                        rx_phase = SER_DATA;
                        rx_ticks = '0;
                    end
                end
                SER_DATA: begin
                    rx_ticks = rx_ticks + 1'b1;
                    if (rx_ticks >= bit_period) begin
                        rx_ticks = '0;
                        if (level)
                            rx_byte[rx_bit[2:0]] = 1'b1;
                        rx_bit = rx_bit + 1'b1;
                        if (rx_bit >= 4'd8)
                            rx_phase = SER_STOP;
                    end
                end
                default: begin
                    rx_ticks = rx_ticks + 1'b1;
                    if (rx_ticks >= bit_period) begin
                        rx_ticks = '0;
                        push_received(invert_en ? ~rx_byte : rx_byte);
                        rx_phase = SER_IDLE;
                    end
                end
            endcase
        end
    endtask

    task automatic advance_transmitter();
        if (tx_phase != SER_IDLE) begin
            tx_ticks = tx_ticks + 1'b1;
            if (tx_ticks >= bit_period) begin
                tx_ticks = '0;
                if (tx_phase == SER_START) begin
                    tx_phase = SER_DATA;
                    tx_bit   = '0;
                end else if (tx_phase == SER_DATA) begin
                    tx_bit = tx_bit + 1'b1;
                    if (tx_bit >= 4'd8)
                        tx_phase = SER_STOP;
                end else begin
                    tx_phase = SER_IDLE;
                end
            end
        end
    endtask

    function automatic logic tx_line_level();
        if (tx_phase == SER_START)
            return invert_en;
        if (tx_phase == SER_DATA)
            return tx_byte[tx_bit[2:0]];
        return ~invert_en;
    endfunction

    task automatic step_uart(input t_in_item beat, output t_out_item res);
        res = '0;
        case (beat.func)
            FUNC_TICK: begin
                advance_receiver(beat.rx_level);
                advance_transmitter();
            end
            FUNC_READ, FUNC_PEEK: begin
                if (listen_en && ring_rd != ring_wr) begin
                    res.read_data  = ring_mem[ring_rd];
                    res.read_valid = 1'b1;
                    if (beat.func == FUNC_READ)
                        ring_rd = ring_rd + 1'b1;
                end
            end
            FUNC_FLUSH: begin
                if (listen_en) begin
                    ring_rd = '0;
                    ring_wr = '0;
                end
            end
            FUNC_WRITE: begin
                if (tx_phase == SER_IDLE) begin
                    tx_byte  = invert_en ? ~beat.tx_byte : beat.tx_byte;
                    tx_phase = SER_START;
                    tx_ticks = '0;
                    tx_bit   = '0;
                    res.write_accepted = 1'b1;
                end
            end
            default: ;
        endcase
        if (listen_en)
            res.fill_count = FILL_W'(ring_wr - ring_rd);
        res.tx_line  = tx_line_level();
        res.overflow = overflow_seen;
        res.tx_busy  = (tx_phase != SER_IDLE);
    endtask

    function automatic bit field_differs(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        bit        bad;
        if (predicted_results.size() == 0) begin
            $display("%0t ns: result beat with nothing expected, expected none, got %h",
                     $time, got);
            o_fail_count++;
        end else begin
            want = predicted_results.pop_front();
            bad  = 1'b0;
            bad  = field_differs("tx_line", want.tx_line, got.tx_line) | bad;
            bad  = field_differs("read_data", want.read_data, got.read_data) | bad;
            bad  = field_differs("read_valid", want.read_valid, got.read_valid) | bad;
            bad  = field_differs("fill_count", want.fill_count, got.fill_count) | bad;
            bad  = field_differs("overflow", want.overflow, got.overflow) | bad;
            bad  = field_differs("tx_busy", want.tx_busy, got.tx_busy) | bad;
            bad  = field_differs("write_accepted", want.write_accepted,
                                 got.write_accepted) | bad;
            if (bad)
                o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item res;
        if (!i_rst_n) begin
            clear_uart_state();
            predicted_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_register(i_paddr[3:2], i_pwdata);
            // Retire the older result beat before queueing the new prediction.
            if (i_out_valid && !i_out_stall)
                check_result(i_out_data);
            if (i_in_valid && !i_in_stall) begin
                step_uart(i_in_data, res);
                predicted_results.push_back(res);
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

/* bench/tb_uart_8n1_transceiver_with_rx_fifo_unit.sv */
`timescale 1ns / 1ps

module tb_uart_8n1_transceiver_with_rx_fifo_unit;
    import uart8_pkg::*;

    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
    localparam logic [1:0] REG_SPARE      = 2'd3;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in_item          in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    int                pending;
    int                fail_count;
    int                items_sent    = 0;
    int                send_gap_pct  = 0;
    int                stall_pct     = 0;
    int                cur_bp        = 104;
    logic              cur_inv       = 1'b0;
    bit                long_hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    uart_8n1_transceiver_with_rx_fifo_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    uart8_link_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    task automatic send_beat(input logic [2:0] func, input logic level, input logic [7:0] data);
        t_in_item beat;
        beat.func     = func;
        beat.rx_level = level;
        beat.tx_byte  = data;
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
    endtask

    // keep_ring swaps ring-draining ops for harmless ones so that the ring fills.
    task automatic send_host_op(input bit keep_ring);
        int         pick;
        logic [2:0] func;
        pick = $urandom_range(99);
        if (pick < 35)
            func = keep_ring ? FUNC_PEEK : FUNC_READ;
        else if (pick < 55)
            func = FUNC_PEEK;
        else if (pick < 82)
            func = FUNC_WRITE;
        else if (pick < 88)
            func = keep_ring ? FUNC_WRITE : FUNC_FLUSH;
        else
            func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        send_beat(func, 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    task automatic send_tick(input logic level, input int host_pct, input bit keep_ring);
        if ($urandom_range(99) < host_pct)
            send_host_op(keep_ring);
        send_beat(FUNC_TICK, level, 8'($urandom_range(255)));
    endtask

    // Drives the line for the given number of bit cells of a frame, LSB first.
    task automatic send_frame(input logic [7:0] value, input int cells, input int stop_at,
                              input int host_pct, input bit keep_ring);
        logic [9:0] frame_bits;
        int         c;
        int         t;
        frame_bits = {1'b1, value, 1'b0};
        for (c = 0; c < cells; c++) begin
            for (t = 0; t < cur_bp; t++) begin
                if (items_sent >= stop_at)
                    return;
                send_tick(frame_bits[c] ^ cur_inv, host_pct, keep_ring);
            end
        end
    endtask

    task automatic run_traffic(input int budget, input int host_pct, input bit keep_ring);
        int stop_at;
        int pick;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame(8'($urandom_range(255)), 10, stop_at, host_pct, keep_ring);
            else if (pick < 82)
                send_frame(8'($urandom_range(255)), $urandom_range(1, 9), stop_at,
                           host_pct, keep_ring);
            else if (pick < 92)
                repeat ($urandom_range(1, 6)) send_tick(~cur_inv, host_pct, keep_ring);
            else
                repeat ($urandom_range(1, 12))
                    send_tick(1'($urandom_range(1)), host_pct, keep_ring);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BIT_PERIOD)
            cur_bp = int'(value[BP_W-1:0]);
        else if (idx == REG_INVERT)
            cur_inv = value[0];
    endtask

    // Receiver side: random stalls, plus one long hold-off that backs the block up.
    initial begin
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && items_sent >= 40) begin
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("uart_8n1_transceiver_with_rx_fifo_unit verification failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct = 20;
        stall_pct    = 86;

        // Receiver off: ring ops do nothing, transmitter still works.
        send_beat(FUNC_READ, 1'b1, 8'h00);
        send_beat(FUNC_PEEK, 1'b0, 8'hff);
        send_beat(FUNC_FLUSH, 1'b1, 8'h00);
        send_beat(FUNC_TICK, 1'b0, 8'h00);
        send_beat(FUNC_WRITE, 1'b0, 8'h00);
        send_beat(FUNC_WRITE, 1'b1, 8'hff);
        send_beat(FUNC_UNUSED_LO, 1'b1, 8'hff);
        send_beat(FUNC_UNUSED_HI, 1'b0, 8'h00);

        write_reg(REG_LISTENING, 32'd1);
        write_reg(REG_BIT_PERIOD, 32'd4);
        send_beat(FUNC_READ, 1'b0, 8'h5a);
        send_beat(FUNC_PEEK, 1'b1, 8'ha5);
        send_beat(FUNC_TICK, 1'b0, 8'h00);
        send_beat(FUNC_TICK, 1'b1, 8'hff);
        send_beat(FUNC_WRITE, 1'b0, 8'hff);
        send_beat(FUNC_FLUSH, 1'b0, 8'h00);
        repeat (8) send_beat(FUNC_TICK, 1'b1, 8'h00);
        send_beat(FUNC_READ, 1'b1, 8'h00);

        run_traffic(60, 12, 1'b0);
        write_reg(REG_BIT_PERIOD, 32'd7);
        write_reg(REG_INVERT, 32'd1);
        run_traffic(50, 12, 1'b0);

        send_gap_pct = 86;
        stall_pct    = 20;
        write_reg(REG_LISTENING, 32'd0);
        run_traffic(20, 25, 1'b0);
        write_reg(REG_LISTENING, 32'd1);
        write_reg(REG_INVERT, 32'd0);
        write_reg(REG_BIT_PERIOD, 32'd65535);
        run_traffic(15, 30, 1'b0);
        // With a bit period of 1 and the line held at the start level,
        // a byte lands every 11 ticks, enough to overrun the ring.
        write_reg(REG_BIT_PERIOD, 32'd1);
        repeat (720) send_tick(cur_inv, 3, 1'b1);

        send_gap_pct = 0;
        stall_pct    = 0;
        write_reg(REG_INVERT, 32'd1);
        write_reg(REG_BIT_PERIOD, 32'($urandom_range(5, 12)));
        run_traffic(35, 45, 1'b0);
        write_reg(REG_SPARE, 32'hffff_ffff);
        write_reg(REG_INVERT, 32'd0);
        write_reg(REG_BIT_PERIOD, 32'($urandom_range(13, 24)));
        run_traffic(25, 15, 1'b0);

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("uart_8n1_transceiver_with_rx_fifo_unit verification clean");
        else
            $display("uart_8n1_transceiver_with_rx_fifo_unit verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/uart8_pkg.sv
rtl/uart8_rx.sv
rtl/uart8_ring.sv
rtl/uart8_8n1_transceiver_with_rx_fifo_unit.sv
bench/uart8_link_checker.sv
bench/tb_uart_8n1_transceiver_with_rx_fifo_unit.sv
